[rtl/assembler_token_scanner_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the assembly token scanner
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLER_TOKEN_SCANNER_DEFINES_SVH
`define ASSEMBLER_TOKEN_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define ATS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define ATS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATS_ASSERT(label, prop, msg)
`define ATS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/ats_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ats_pkg
// Types, constants and byte classes for the assembly token scanner.
// ----------------------------------------------------------------------------
package ats_pkg;

  localparam int SOURCE_MAX = 1048576;

  localparam int CH_W   = 8;
  localparam int KIND_W = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 20;
  localparam int LEN_W  = 21;
  localparam int LINE_W = 16;
  localparam int MAX_RES = 3;
  localparam int CNT_W  = 2;

  localparam logic [POS_W-1:0]  POS_LIMIT  = POS_W'(SOURCE_MAX - 1);
  localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(SOURCE_MAX);
  localparam logic [LINE_W-1:0] LINE_LIMIT = '1;

  localparam logic [CH_W-1:0] CH_NUL   = 8'd0;
  localparam logic [CH_W-1:0] CH_NL    = 8'd10;
  localparam logic [CH_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CH_W-1:0] CH_MINUS = 8'd45;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_SIGN,
    MODE_HALT
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WORD     = 3'd0,
    KIND_NUM      = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_SIGN_ERR = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [POS_W-1:0]   byte_pos;
    logic [LINE_W-1:0]  line_count;
    logic [POS_W-1:0]   token_start;
    logic [LINE_W-1:0]  token_line;
    logic [LEN_W-1:0]   token_len;
    logic [VAL_W-1:0]   accum;
    logic               negative;
  } scan_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   value;
    logic [POS_W-1:0]   start_pos;
    logic [LEN_W-1:0]   length;
    logic [LINE_W-1:0]  line_no;
    logic [CH_W-1:0]    char_code;
  } tok_t;

  function automatic logic is_ws(input logic [CH_W-1:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic tok_t make_tok(input kind_t k, input logic [VAL_W-1:0] v,
                                    input logic [POS_W-1:0] p,
                                    input logic [LEN_W-1:0] l,
                                    input logic [LINE_W-1:0] ln,
                                    input logic [CH_W-1:0] c);
    tok_t t;
    t.kind      = k;
    t.value     = v;
    t.start_pos = p;
    t.length    = l;
    t.line_no   = ln;
    t.char_code = c;
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/ats_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner channels
// Byte input channel and token output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ats_in_if;
  logic                      valid;
  logic                      ready;
  logic [ats_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source(output valid, output ch, output last, input ready);
  modport sink(input valid, input ch, input last, output ready);
endinterface

interface ats_out_if;
  logic                             valid;
  logic                             ready;
  logic [ats_pkg::KIND_W-1:0]       kind;
  logic signed [ats_pkg::VAL_W-1:0] value;
  logic [ats_pkg::POS_W-1:0]        start_pos;
  logic [ats_pkg::LEN_W-1:0]        length;
  logic [ats_pkg::LINE_W-1:0]       line_no;
  logic [ats_pkg::CH_W-1:0]         char_code;
  logic                             last_result;

  modport source(output valid, output kind, output value, output start_pos,
                 output length, output line_no, output char_code,
                 output last_result, input ready);
  modport sink(input valid, input kind, input value, input start_pos,
               input length, input line_no, input char_code,
               input last_result, output ready);
endinterface
`default_nettype wire

[rtl/ats_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ats_step
// Next scanner state and up to three tokens for one source byte.
// ----------------------------------------------------------------------------
module ats_step (
  input  ats_pkg::scan_state_t                     cur,
  input  logic [ats_pkg::CH_W-1:0]                 ch,
  input  logic                                     last,
  output ats_pkg::scan_state_t                     nxt,
  output ats_pkg::tok_t [ats_pkg::MAX_RES-1:0]     res,
  output logic [ats_pkg::CNT_W-1:0]                cnt
);
  import ats_pkg::*;

  logic [VAL_W-1:0] times_ten;
  logic [VAL_W-1:0] digit;

  assign digit     = {{(VAL_W-4){1'b0}}, ch[3:0]};
  assign times_ten = {cur.accum[VAL_W-4:0], 3'b000} + {cur.accum[VAL_W-2:0], 1'b0} + digit;

  always_comb begin
    scan_state_t                 s;
    tok_t [MAX_RES-1:0]          r;
    logic [CNT_W-1:0]            n;
    logic                        idle_h;
    logic                        fin;
    s      = cur;
    r      = '0;
    n      = '0;
    idle_h = 1'b0;
    fin    = 1'b0;

    unique case (cur.mode)
      MODE_HALT: begin
        fin = 1'b1;
      end
      MODE_SIGN: begin
        if (is_digit(ch)) begin
          s.accum = digit;
          s.mode  = MODE_NUM;
        end else begin
          r[n] = make_tok(KIND_SIGN_ERR, '0, cur.token_start, '0, cur.token_line, ch);
          n    = n + 1'b1;
          s.mode = MODE_HALT;
          fin    = 1'b1;
        end
      end
      MODE_NUM: begin
        if (is_digit(ch)) begin
          s.accum = times_ten;
        end else begin
          num_val_push: begin
            r[n] = make_tok(KIND_NUM, cur.negative ? (VAL_W'(0) - cur.accum) : cur.accum,
                            cur.token_start, '0, cur.token_line, '0);
            n    = n + 1'b1;
          end
          s.mode = MODE_IDLE;
          idle_h = 1'b1;
        end
      end
      MODE_WORD: begin
        if (ch != CH_NUL && !is_ws(ch) && ch != CH_COMMA) begin
          if (cur.token_len < LEN_LIMIT) s.token_len = cur.token_len + 1'b1;
        end else begin
          r[n] = make_tok(KIND_WORD, '0, cur.token_start, cur.token_len,
                          cur.token_line, '0);
          n    = n + 1'b1;
          s.mode = MODE_IDLE;
          idle_h = 1'b1;
        end
      end
      MODE_IDLE: begin
        idle_h = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase

    if (idle_h) begin
      if (ch == CH_NUL) begin
        r[n] = make_tok(KIND_END, '0, cur.byte_pos, '0, s.line_count, '0);
        n    = n + 1'b1;
        s.mode = MODE_HALT;
        fin    = 1'b1;
      end else if (is_ws(ch)) begin
        if (ch == CH_NL && s.line_count < LINE_LIMIT) s.line_count = s.line_count + 1'b1;
      end else if (is_alpha(ch)) begin
        s.mode        = MODE_WORD;
        s.token_start = cur.byte_pos;
        s.token_line  = s.line_count;
        s.token_len   = LEN_W'(1);
      end else if (is_digit(ch) || ch == CH_MINUS) begin
        s.mode        = (ch == CH_MINUS) ? MODE_SIGN : MODE_NUM;
        s.token_start = cur.byte_pos;
        s.token_line  = s.line_count;
        s.negative    = (ch == CH_MINUS);
        s.accum       = (ch == CH_MINUS) ? '0 : digit;
      end else begin
        r[n] = make_tok(KIND_UNKNOWN, '0, cur.byte_pos, '0, s.line_count, ch);
        n    = n + 1'b1;
      end
    end

    if (!fin) begin
      if (cur.byte_pos < POS_LIMIT) s.byte_pos = cur.byte_pos + 1'b1;
      if (last) begin
        if (s.mode == MODE_WORD) begin
          r[n] = make_tok(KIND_WORD, '0, s.token_start, s.token_len, s.token_line, '0);
          n    = n + 1'b1;
        end else if (s.mode == MODE_NUM) begin
          r[n] = make_tok(KIND_NUM, s.negative ? (VAL_W'(0) - s.accum) : s.accum,
                          s.token_start, '0, s.token_line, '0);
          n    = n + 1'b1;
        end
        if (s.mode == MODE_SIGN) begin
          // source ended right after '-'
          r[n] = make_tok(KIND_SIGN_ERR, '0, s.token_start, '0, s.token_line, '0);
          n    = n + 1'b1;
        end else begin
          r[n] = make_tok(KIND_END, '0, cur.byte_pos + 1'b1, '0, s.line_count, '0);
          n    = n + 1'b1;
        end
        s.mode = MODE_HALT;
      end
    end

    nxt     = s;
    res     = r;
    cnt     = n;
  end

endmodule
`default_nettype wire

[rtl/assembler_token_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// assembler_token_scanner
// Assembly source lexer: bytes in, mnemonic/number/unknown/error/end tokens out.
// ----------------------------------------------------------------------------
// Output: the first token of a byte shows in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one token and the
//   output is ready; a byte yielding more tokens (up to 3) holds the input until
//   the single-token output port has drained the token buffer.
// Reset (rst, synchronous): scanner idle at offset 0, line 1, buffer empty.
// ----------------------------------------------------------------------------
`include "assembler_token_scanner_defines.svh"

module assembler_token_scanner (
  input  logic      clk,
  input  logic      rst,
  ats_in_if.sink    src,
  ats_out_if.source tok
);
  import ats_pkg::*;

  // Scanner state: mode, position, line, pending token fields.
  scan_state_t st;
  scan_state_t st_next;

  // Tokens from the step logic for the byte at the input.
  tok_t [MAX_RES-1:0] step_res;
  logic [CNT_W-1:0]   step_cnt;

  // Token buffer: tokens of one byte, head in slot 0, shifted on each pop.
  tok_t [MAX_RES-1:0] bnd;
  logic [CNT_W-1:0]   bnd_cnt;

  logic acc;
  logic pop;

  ats_step u_step (
    .cur  (st),
    .ch   (src.ch),
    .last (src.last),
    .nxt  (st_next),
    .res  (step_res),
    .cnt  (step_cnt)
  );

  // Take a new byte once the buffer is empty or its final token leaves now.
  // A byte that yields no token still needs a free buffer slot so order holds.
  assign src.ready = (bnd_cnt == '0) || (bnd_cnt == CNT_W'(1) && tok.ready);
  assign acc       = src.valid && src.ready;
  assign pop       = tok.valid && tok.ready;

  // State advances only on an accepted byte; halted mode swallows bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= MODE_IDLE;
      st.byte_pos    <= '0;
      st.line_count  <= LINE_W'(1);
      st.token_start <= '0;
      st.token_line  <= LINE_W'(1);
      st.token_len   <= '0;
      st.accum       <= '0;
      st.negative    <= 1'b0;
    end else if (acc) begin
      st <= st_next;
    end
  end

  // Buffer count: load on accept (old contents are gone by then), else drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      bnd_cnt <= '0;
    end else if (acc) begin
      bnd_cnt <= step_cnt;
    end else if (pop) begin
      bnd_cnt <= bnd_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      bnd <= step_res;
    end else if (pop) begin
      bnd <= {tok_t'('0), bnd[MAX_RES-1:1]};
    end
  end

  assign tok.valid       = (bnd_cnt != '0);
  assign tok.kind        = bnd[0].kind;
  assign tok.value       = bnd[0].value;
  assign tok.start_pos   = bnd[0].start_pos;
  assign tok.length      = bnd[0].length;
  assign tok.line_no     = bnd[0].line_no;
  assign tok.char_code   = bnd[0].char_code;
  // Final token of its byte when only it remains.
  assign tok.last_result = (bnd_cnt == CNT_W'(1));

  `ATS_ASSERT(a_accept_drained, acc |-> (bnd_cnt == '0 || (bnd_cnt == CNT_W'(1) && pop)), "byte accepted over pending tokens")
  `ATS_ASSERT(a_halt_sticks, (st.mode == MODE_HALT) |=> (st.mode == MODE_HALT), "scanner left halt without reset")
  `ATS_ASSERT(a_halt_silent, (acc && st.mode == MODE_HALT) |=> (bnd_cnt == '0), "token produced while halted")
  `ATS_ASSERT(a_end_is_final, (tok.valid && tok.kind == KIND_END) |-> tok.last_result, "end marker not final token of its byte")
  `ATS_ASSERT_ALWAYS(a_line_nonzero, (rst || st.line_count != '0), "line counter reached zero")

endmodule
`default_nettype wire
